FILE: src/brsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap RLE span decoder package
// Shared types, record phases, result kinds and register indexes.
// ----------------------------------------------------------------------------
package brsd_pkg;

  localparam int MAX_DIM_DEFAULT = 16384;
  localparam int CFG_W = 15;
  localparam int CFG_INDEX_W = 2;
  localparam int SPAN_POS_W = 14;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FOUR_BIT_MODE = 2'd2;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET = 15'd1;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 15'd1;

  localparam logic KIND_SPAN = 1'b0;
  localparam logic KIND_END = 1'b1;

  localparam logic [7:0] ESC_LINE_END = 8'd0;
  localparam logic [7:0] ESC_BITMAP_END = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef enum logic [2:0] {
    PH_FIRST = 3'd0,
    PH_SECOND = 3'd1,
    PH_ABS_DATA = 3'd2,
    PH_ABS_PAD = 3'd3,
    PH_DELTA_X = 3'd4,
    PH_DELTA_Y = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic                  result_kind;
    logic [SPAN_POS_W-1:0] span_column;
    logic [SPAN_POS_W-1:0] span_row;
    logic [7:0]            span_length;
    logic [7:0]            first_color;
    logic [7:0]            second_color;
  } out_t;

endpackage
`default_nettype wire

FILE: src/bmp_rle_span_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap RLE span decoder
// Decodes an RLE8 or RLE4 compressed bitmap byte stream into span writes.
// ----------------------------------------------------------------------------
// The decoder takes one compressed byte per cycle for as long as the result
// side keeps up. An accepted byte lands in an input register; from there the
// record update and span clipping for that byte run in one pass and the
// result, if any, is loaded into the output register. Bytes that produce no
// result still take one slot of that pass. A byte waits in the input register
// while a result is held by a stalled output, and the input stalls until it
// moves on. Registers must be written only while the decoder is idle;
// image_height is sampled at reset and at each frame start.
// ----------------------------------------------------------------------------
module bmp_rle_span_decoder #(
  parameter int MAX_DIM = brsd_pkg::MAX_DIM_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  brsd_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output brsd_pkg::out_t                   out_data,
  input  logic                             cfg_wr_en,
  input  logic [brsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [brsd_pkg::CFG_W-1:0]       cfg_data
);

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int EW = (DW > brsd_pkg::CFG_W) ? DW : brsd_pkg::CFG_W;
  localparam int XW = ((DW > 8) ? DW : 8) + 1;

  logic [brsd_pkg::CFG_W-1:0] image_width;
  logic [brsd_pkg::CFG_W-1:0] image_height;
  logic                       four_bit_mode;

  brsd_pkg::phase_t phase, phase_next;
  logic [DW-1:0]    column_pos, column_pos_next;
  logic [DW-1:0]    row_pos, row_pos_next;
  logic [7:0]       held_first_byte, held_first_byte_next;
  logic [7:0]       absolute_left, absolute_left_next;
  logic             absolute_odd_bytes, absolute_odd_bytes_next;
  logic [7:0]       delta_columns, delta_columns_next;
  logic             decode_done, decode_done_next;

  logic           s1_valid;
  brsd_pkg::in_t  s1_data;
  brsd_pkg::out_t result;
  logic           emit;
  logic           advance;

  logic [DW-1:0] width_eff;
  logic [DW-1:0] height_eff;
  logic [7:0]    b;
  logic [7:0]    per_byte;
  logic [7:0]    take;
  logic [7:0]    want;
  logic [7:0]    row_sub;
  logic [XW-1:0] col_sum;
  logic [XW-1:0] row_diff;
  logic          row_negative;
  logic [7:0]    span_len;
  logic [7:0]    span_c0;
  logic [7:0]    span_c1;
  logic [DW-1:0] span_col_after;
  brsd_pkg::phase_t cur_phase;
  logic          cur_done;

  assign width_eff = (EW'(image_width) > EW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(image_width);
  assign height_eff = (EW'(image_height) > EW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(image_height);

  assign b = s1_data.stream_byte;
  assign cur_phase = s1_data.frame_start ? brsd_pkg::PH_FIRST : phase;
  assign cur_done = decode_done && !s1_data.frame_start;

  assign per_byte = four_bit_mode ? 8'd2 : 8'd1;
  assign take = (absolute_left < per_byte) ? absolute_left : per_byte;
  assign want = (phase == brsd_pkg::PH_SECOND) ? held_first_byte : take;

  assign row_sub = (phase == brsd_pkg::PH_DELTA_Y) ? b : 8'd1;
  assign col_sum = XW'(column_pos) + XW'(delta_columns);
  assign row_diff = XW'(row_pos) - XW'(row_sub);
  assign row_negative = row_diff[XW-1];

  brsd_span #(
    .MAX_DIM(MAX_DIM)
  ) u_span (
    .column_pos   (column_pos),
    .width_eff    (width_eff),
    .want         (want),
    .pix          (b),
    .four_bit_mode(four_bit_mode),
    .length       (span_len),
    .first_color  (span_c0),
    .second_color (span_c1),
    .column_after (span_col_after)
  );

  always_comb begin
    phase_next = phase;
    column_pos_next = column_pos;
    row_pos_next = row_pos;
    held_first_byte_next = held_first_byte;
    absolute_left_next = absolute_left;
    absolute_odd_bytes_next = absolute_odd_bytes;
    delta_columns_next = delta_columns;
    decode_done_next = decode_done;
    emit = 1'b0;
    result = '0;

    if (s1_data.frame_start) begin
      phase_next = brsd_pkg::PH_FIRST;
      column_pos_next = '0;
      row_pos_next = height_eff - DW'(1);
      held_first_byte_next = '0;
      absolute_left_next = '0;
      absolute_odd_bytes_next = 1'b0;
      delta_columns_next = '0;
      decode_done_next = 1'b0;
    end

    if (s1_data.frame_start && (height_eff == '0)) begin
      decode_done_next = 1'b1;
      emit = 1'b1;
      result.result_kind = brsd_pkg::KIND_END;
    end else if (!cur_done) begin
      case (cur_phase)
        brsd_pkg::PH_FIRST: begin
          held_first_byte_next = b;
          phase_next = brsd_pkg::PH_SECOND;
        end
        brsd_pkg::PH_SECOND: begin
          phase_next = brsd_pkg::PH_FIRST;
          if (held_first_byte != 8'd0) begin
            if (span_len != 8'd0) begin
              emit = 1'b1;
              column_pos_next = span_col_after;
            end
          end else if (b == brsd_pkg::ESC_LINE_END) begin
            row_pos_next = DW'(row_diff);
            column_pos_next = '0;
            if (row_negative) begin
              decode_done_next = 1'b1;
              emit = 1'b1;
              result.result_kind = brsd_pkg::KIND_END;
            end
          end else if (b == brsd_pkg::ESC_BITMAP_END) begin
            decode_done_next = 1'b1;
            emit = 1'b1;
            result.result_kind = brsd_pkg::KIND_END;
          end else if (b == brsd_pkg::ESC_DELTA) begin
            phase_next = brsd_pkg::PH_DELTA_X;
          end else begin
            absolute_left_next = b;
            absolute_odd_bytes_next = 1'b0;
            phase_next = brsd_pkg::PH_ABS_DATA;
          end
        end
        brsd_pkg::PH_ABS_DATA: begin
          absolute_left_next = absolute_left - take;
          absolute_odd_bytes_next = !absolute_odd_bytes;
          if (absolute_left_next == 8'd0) begin
            phase_next = absolute_odd_bytes_next ? brsd_pkg::PH_ABS_PAD : brsd_pkg::PH_FIRST;
          end
          if (span_len != 8'd0) begin
            emit = 1'b1;
            column_pos_next = span_col_after;
          end
        end
        brsd_pkg::PH_ABS_PAD: begin
          phase_next = brsd_pkg::PH_FIRST;
        end
        brsd_pkg::PH_DELTA_X: begin
          delta_columns_next = b;
          phase_next = brsd_pkg::PH_DELTA_Y;
        end
        default: begin
          phase_next = brsd_pkg::PH_FIRST;
          column_pos_next = DW'(col_sum);
          row_pos_next = DW'(row_diff);
          if (row_negative || (col_sum > XW'(width_eff))) begin
            decode_done_next = 1'b1;
            emit = 1'b1;
            result.result_kind = brsd_pkg::KIND_END;
          end
        end
      endcase
    end

    if (emit && (result.result_kind == brsd_pkg::KIND_SPAN)) begin
      result.span_column = brsd_pkg::SPAN_POS_W'(column_pos);
      result.span_row = brsd_pkg::SPAN_POS_W'(row_pos);
      result.span_length = span_len;
      result.first_color = span_c0;
      result.second_color = span_c1;
    end
  end

  assign advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= brsd_pkg::IMAGE_WIDTH_RESET;
      image_height <= brsd_pkg::IMAGE_HEIGHT_RESET;
      four_bit_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        brsd_pkg::CFG_IMAGE_WIDTH: image_width <= cfg_data;
        brsd_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        brsd_pkg::CFG_FOUR_BIT_MODE: four_bit_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= brsd_pkg::PH_FIRST;
      column_pos <= '0;
      row_pos <= DW'(brsd_pkg::IMAGE_HEIGHT_RESET) - DW'(1);
      held_first_byte <= '0;
      absolute_left <= '0;
      absolute_odd_bytes <= 1'b0;
      delta_columns <= '0;
      decode_done <= 1'b0;
    end else if (advance) begin
      phase <= phase_next;
      column_pos <= column_pos_next;
      row_pos <= row_pos_next;
      held_first_byte <= held_first_byte_next;
      absolute_left <= absolute_left_next;
      absolute_odd_bytes <= absolute_odd_bytes_next;
      delta_columns <= delta_columns_next;
      decode_done <= decode_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= emit;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire

FILE: src/brsd_span.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Span writer
// Clips a requested pixel count at the row width, gives the column after the
// span, and in four-bit mode splits the pixel byte into two nibble colors.
// ----------------------------------------------------------------------------
module brsd_span #(
  parameter int MAX_DIM = brsd_pkg::MAX_DIM_DEFAULT,
  localparam int DW = $clog2(MAX_DIM + 1)
) (
  input  logic [DW-1:0] column_pos,
  input  logic [DW-1:0] width_eff,
  input  logic [7:0]    want,
  input  logic [7:0]    pix,
  input  logic          four_bit_mode,
  output logic [7:0]    length,
  output logic [7:0]    first_color,
  output logic [7:0]    second_color,
  output logic [DW-1:0] column_after
);

  localparam int CW = (DW > 8) ? DW : 8;

  logic [DW-1:0] room;

  assign room = (column_pos < width_eff) ? (width_eff - column_pos) : '0;
  assign length = (CW'(want) < CW'(room)) ? want : 8'(room);
  assign column_after = column_pos + DW'(length);

  always_comb begin
    if (four_bit_mode) begin
      first_color = {4'h0, pix[7:4]};
      second_color = {4'h0, pix[3:0]};
    end else begin
      first_color = pix;
      second_color = pix;
    end
  end

endmodule
`default_nettype wire
